// File: hdl/tsdf_pkg.sv
// Shared types and constants for the text stream display filter.
// No dependencies; every other file of the block but tsdf_ifs imports this package.
package tsdf_pkg;

  localparam int NUMBER_WIDTH_DEF = 6;
  localparam int DIGITS = 6;
  localparam int DIGIT_IDX_W = $clog2(DIGITS);
  localparam int ND_W = $clog2(DIGITS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_NL = 8'd10;
  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_DEL = 8'd127;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO = 8'h30;
  localparam logic [7:0] BYTE_CARET = 8'h5e;
  localparam logic [7:0] BYTE_DOLLAR = 8'h24;
  localparam logic [7:0] BYTE_QMARK = 8'h3f;
  localparam logic [7:0] BYTE_LETTER_I = 8'h49;
  localparam logic [7:0] BYTE_FIRST_PRINT = 8'd32;
  localparam logic [7:0] BYTE_FIRST_HIGH = 8'd128;
  localparam logic [7:0] CTL_OFFSET = 8'd64;
  localparam logic [3:0] BCD_NINE = 4'd9;

  localparam logic [1:0] NUM_ALL = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;
  localparam logic [1:0] RUN_SUPPRESS = 2'd3;

  typedef enum logic [2:0] {
    REG_SHOW_NONPRINTING = 3'd0,
    REG_SHOW_LINE_ENDS   = 3'd1,
    REG_SHOW_TABS        = 3'd2,
    REG_NUMBERING        = 3'd3,
    REG_SQUEEZE_BLANK    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       show_nonprinting;
    logic       show_line_ends;
    logic       show_tabs;
    logic [1:0] numbering;
    logic       squeeze_blank;
  } tsdf_cfg_t;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic            with_num;
    bcd_t            digits;
    logic [ND_W-1:0] nd;
    logic            caret;
    logic            dollar;
    logic [7:0]      ch;
  } tsdf_job_t;

endpackage

// File: hdl/tsdf_ifs.sv
// Valid/ready channel interfaces for the input text and the displayed text.
// No dependencies.
interface tsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tsdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hdl/tsdf_regs.sv
// APB-style configuration registers of the display filter.
// Depends on tsdf_pkg.
module tsdf_regs import tsdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output tsdf_cfg_t         cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= pwdata[0];
        REG_SHOW_LINE_ENDS:   cfg.show_line_ends <= pwdata[0];
        REG_SHOW_TABS:        cfg.show_tabs <= pwdata[0];
        REG_NUMBERING:        cfg.numbering <= pwdata[1:0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SHOW_NONPRINTING: prdata[0] = cfg.show_nonprinting;
      REG_SHOW_LINE_ENDS:   prdata[0] = cfg.show_line_ends;
      REG_SHOW_TABS:        prdata[0] = cfg.show_tabs;
      REG_NUMBERING:        prdata[1:0] = cfg.numbering;
      REG_SQUEEZE_BLANK:    prdata[0] = cfg.squeeze_blank;
      default:              prdata = '0;
    endcase
  end

endmodule

// File: hdl/tsdf_front.sv
// Front end: accepts input words, translates them, keeps line state and queues output jobs.
// Depends on tsdf_pkg and tsdf_ifs.
module tsdf_front import tsdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsdf_in_if.sink   text,
  input  tsdf_cfg_t cfg,
  input  logic      q_full,
  output logic      push,
  output tsdf_job_t job
);

  logic       prev_nl;
  logic [1:0] run;
  bcd_t       count;

  logic       run_next;
  logic [1:0] run_val;
  bcd_t       count_next;
  bcd_t       count_inc;
  logic       accept;
  logic       incr;
  logic       with_num;
  logic       caret;
  logic [7:0] raw;
  logic [7:0] ch;
  logic       carry;
  logic       all_nine;
  logic [ND_W-1:0] nd;

  assign text.ready = !q_full;
  assign accept = text.valid && !q_full;
  assign raw = text.in_byte;

  always_comb begin
    caret = 1'b0;
    ch = raw;
    if (cfg.show_nonprinting) begin
      if (raw == BYTE_DEL) begin
        caret = 1'b1;
        ch = BYTE_QMARK;
      end else if ((raw < BYTE_FIRST_PRINT || raw >= BYTE_FIRST_HIGH) && raw != BYTE_TAB &&
                   raw != BYTE_NL && raw != BYTE_CR) begin
        caret = 1'b1;
        ch = raw + CTL_OFFSET;
      end
    end
    if (cfg.show_tabs && ch == BYTE_TAB) begin
      caret = 1'b1;
      ch = BYTE_LETTER_I;
    end

    incr = 1'b0;
    with_num = 1'b0;
    if (cfg.numbering >= NUM_NONBLANK) begin
      if (prev_nl && raw != BYTE_NL) begin
        incr = 1'b1;
        with_num = 1'b1;
      end
    end else if (cfg.numbering == NUM_ALL) begin
      if (prev_nl) begin
        incr = (run != RUN_SUPPRESS);
        with_num = 1'b1;
      end
    end

    carry = 1'b1;
    all_nine = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      count_inc[i] = count[i];
      if (carry) begin
        count_inc[i] = (count[i] == BCD_NINE) ? 4'd0 : count[i] + 4'd1;
      end
      carry = carry && (count[i] == BCD_NINE);
      all_nine = all_nine && (count[i] == BCD_NINE);
    end
    count_next = (incr && !all_nine) ? count_inc : count;

    nd = ND_W'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (count_next[i] != 4'd0) begin
        nd = ND_W'(i + 1);
      end
    end

    run_val = run;
    run_next = 1'b0;
    if (cfg.squeeze_blank && ch == BYTE_NL && run != RUN_SUPPRESS) begin
      run_val = run + 2'd1;
    end
    if (ch != BYTE_NL) begin
      run_val = 2'd0;
    end
    run_next = (run_val == RUN_SUPPRESS);

    job.with_num = with_num;
    job.digits = count_next;
    job.nd = nd;
    job.caret = caret;
    job.dollar = cfg.show_line_ends && raw == BYTE_NL;
    job.ch = ch;
  end

  assign push = accept && !run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_nl <= 1'b1;
      run <= 2'd0;
      count <= '0;
    end else if (accept) begin
      prev_nl <= (raw == BYTE_NL);
      run <= run_val;
      count <= count_next;
    end
  end

endmodule

// File: hdl/tsdf_queue.sv
// Short job queue between the front end and the output sequencer.
// Depends on tsdf_pkg.
module tsdf_queue import tsdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tsdf_job_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output tsdf_job_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  tsdf_job_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/tsdf_back.sv
// Output sequencer: expands each queued job into number, tab, caret, dollar and byte words.
// Depends on tsdf_pkg and tsdf_ifs.
module tsdf_back import tsdf_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  tsdf_job_t  head,
  output logic       pop,
  tsdf_out_if.source display
);

  localparam int COLS_MAX = (NUMBER_WIDTH > DIGITS) ? NUMBER_WIDTH : DIGITS;
  localparam int CW = $clog2(COLS_MAX);
  localparam logic [CW-1:0] NW_M1 = CW'(NUMBER_WIDTH - 1);

  typedef enum logic [4:0] {
    PH_NUM    = 5'b00001,
    PH_TAB    = 5'b00010,
    PH_CARET  = 5'b00100,
    PH_DOLLAR = 5'b01000,
    PH_CHAR   = 5'b10000
  } phase_t;

  logic          mid;
  phase_t        phase;
  logic [CW-1:0] cnt;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;

  phase_t        first_phase;
  phase_t        eff_phase;
  phase_t        phase_next;
  logic [CW-1:0] start;
  logic [CW-1:0] nd_m1;
  logic [CW-1:0] eff_cnt;
  logic [CW-1:0] cnt_next;
  logic [7:0]    word;
  logic          last;
  logic          load;

  assign load = head_valid && (!out_valid || display.ready);
  assign pop = load && last;

  always_comb begin
    nd_m1 = CW'(head.nd - ND_W'(1));
    start = (nd_m1 > NW_M1) ? nd_m1 : NW_M1;
    if (head.with_num) begin
      first_phase = PH_NUM;
    end else if (head.caret) begin
      first_phase = PH_CARET;
    end else if (head.dollar) begin
      first_phase = PH_DOLLAR;
    end else begin
      first_phase = PH_CHAR;
    end
    eff_phase = mid ? phase : first_phase;
    eff_cnt = mid ? cnt : start;

    word = head.ch;
    last = 1'b0;
    phase_next = PH_CHAR;
    cnt_next = eff_cnt;
    unique case (eff_phase)
      PH_NUM: begin
        if (eff_cnt < CW'(head.nd)) begin
          word = BYTE_ZERO | {4'd0, head.digits[eff_cnt[DIGIT_IDX_W-1:0]]};
        end else begin
          word = BYTE_SPACE;
        end
        if (eff_cnt == '0) begin
          phase_next = PH_TAB;
        end else begin
          phase_next = PH_NUM;
          cnt_next = eff_cnt - CW'(1);
        end
      end
      PH_TAB: begin
        word = BYTE_TAB;
        if (head.caret) begin
          phase_next = PH_CARET;
        end else if (head.dollar) begin
          phase_next = PH_DOLLAR;
        end else begin
          phase_next = PH_CHAR;
        end
      end
      PH_CARET: begin
        word = BYTE_CARET;
        phase_next = head.dollar ? PH_DOLLAR : PH_CHAR;
      end
      PH_DOLLAR: begin
        word = BYTE_DOLLAR;
        phase_next = PH_CHAR;
      end
      PH_CHAR: begin
        word = head.ch;
        last = 1'b1;
      end
      default: begin
        word = head.ch;
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
      phase <= PH_CHAR;
      cnt <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      mid <= !last;
      phase <= phase_next;
      cnt <= cnt_next;
      out_valid <= 1'b1;
    end else if (display.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= word;
      out_last <= last;
    end
  end

  assign display.valid = out_valid;
  assign display.out_byte = out_byte;
  assign display.last_of_run = out_last;

  a_mid_needs_job: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !mid)
    else $error("sequencer is inside a job while the queue is empty");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    load && last |=> !mid)
    else $error("sequencer still inside a job after its final word");

  a_more_words: assert property (@(posedge clk) disable iff (rst)
    load && !last |=> mid && head_valid)
    else $error("job left before its final word was sent");

endmodule

// File: hdl/text_stream_display_filter_unit.sv
// Top level of the text stream display filter.
// Depends on tsdf_pkg, tsdf_ifs, tsdf_regs, tsdf_front, tsdf_queue and tsdf_back.
//
// Each word on raw_text carries one byte of a text stream. For it the block sends zero or
// more words on display_text: an optional line number padded to NUMBER_WIDTH columns and a
// tab, an optional caret, an optional dollar sign and the shown byte, the final word of the
// run carrying last_of_run. A squeezed blank line yields no words at all.
// The front end takes one input word per cycle while its four-entry job queue has room; the
// output sequencer sends one word per cycle while display_text is ready, and an input
// expands to n words (n is at most max(NUMBER_WIDTH, 6) + 3). An accepted input word is
// written into the job queue, and its words are then registered in the output register.
// When display_text stalls, the output register holds its word, the queue fills and then
// raw_text drops ready; nothing is lost.
// Reset clears the options, the line counter and the blank-run state and empties the queue.
// Options are written over the APB port at byte address 4 * index and should be changed
// only while the block is idle.
module text_stream_display_filter_unit import tsdf_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tsdf_in_if.sink           raw_text,
  tsdf_out_if.source        display_text,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  tsdf_cfg_t cfg;
  tsdf_job_t push_data;
  tsdf_job_t head;
  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;

  assign pready = 1'b1;

  tsdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tsdf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (raw_text),
    .cfg    (cfg),
    .q_full (full),
    .push   (push),
    .job    (push_data)
  );

  tsdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tsdf_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .display    (display_text)
  );

endmodule

// File: dv/text_stream_display_filter_unit_test.sv
// Self-checking testbench for text_stream_display_filter_unit: directed and random text
// streams under several option settings, checked word by word against a local predictor.
// Depends on tsdf_pkg, the tsdf_in_if/tsdf_out_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module text_stream_display_filter_unit_test import tsdf_pkg::*;;

  localparam int NUM_COLS = NUMBER_WIDTH_DEF;
  localparam logic [19:0] LINE_NO_MAX = 20'd999999;
  localparam logic [1:0] NUM_BOTH_BITS = NUM_ALL | NUM_NONBLANK;
  localparam logic [7:0] WRAP_TAB = 8'd201;
  localparam logic [7:0] WRAP_NL = 8'd202;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_CAP = 200;
  localparam int PHASE_ITEMS = 26;
  localparam int WRAP_PAIRS = 4;

  typedef enum logic [1:0] {
    PACE_STEADY,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } shown_word_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tsdf_in_if raw_text ();
  tsdf_out_if display_text ();

  text_stream_display_filter_unit #(.NUMBER_WIDTH(NUM_COLS)) DUT (
    .clk(clk),
    .rst(rst),
    .raw_text(raw_text),
    .display_text(display_text),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  tsdf_cfg_t opt = '0;
  logic at_line_start = 1'b1;
  logic [1:0] blank_run = '0;
  logic [19:0] line_no = '0;

  shown_word_t expected_words[$];
  shown_word_t oldest_word;
  pace_t pace = PACE_STEADY;
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_pct(input logic receiver);
    if (pace == PACE_BOTH) return 33;
    if (receiver && pace == PACE_RECV_STALLS) return 55;
    if (!receiver && pace == PACE_SEND_GAPS) return 55;
    return 0;
  endfunction

  always @(posedge clk) begin
    display_text.ready <= ($urandom_range(99) >= idle_pct(1'b1));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && display_text.valid && display_text.ready) begin
      if (expected_words.size() == 0) begin
        if (error_count < REPORT_CAP)
          $display("%0t: unexpected word, expected none, got %h last %b", $time,
                   display_text.out_byte, display_text.last_of_run);
        error_count++;
      end else begin
        oldest_word = expected_words.pop_front();
        if (display_text.out_byte !== oldest_word.text ||
            display_text.last_of_run !== oldest_word.last) begin
          if (error_count < REPORT_CAP)
            $display("%0t: word mismatch, expected %h last %b, got %h last %b", $time,
                     oldest_word.text, oldest_word.last,
                     display_text.out_byte, display_text.last_of_run);
          error_count++;
        end
      end
    end
  end

  task automatic predict_display(input logic [7:0] raw);
    logic [7:0] shown;
    logic caret;
    logic dollar;
    logic numbered;
    logic [19:0] v;
    logic [7:0] digit_chars[$];
    logic [7:0] words[$];
    int i;
    shown = raw;
    caret = 1'b0;
    numbered = 1'b0;
    if (opt.show_nonprinting) begin
      if (raw == BYTE_DEL) begin
        caret = 1'b1;
        shown = BYTE_QMARK;
      end else if ((raw < BYTE_FIRST_PRINT || raw >= BYTE_FIRST_HIGH) && raw != BYTE_TAB &&
                   raw != BYTE_NL && raw != BYTE_CR) begin
        caret = 1'b1;
        shown = raw + CTL_OFFSET;
      end
    end
    if (opt.numbering >= NUM_NONBLANK) begin
      if (at_line_start && raw != BYTE_NL) begin
        if (line_no < LINE_NO_MAX) line_no++;
        numbered = 1'b1;
      end
    end else if (opt.numbering == NUM_ALL && at_line_start) begin
      if (blank_run < RUN_SUPPRESS && line_no < LINE_NO_MAX) line_no++;
      numbered = 1'b1;
    end
    if (opt.show_tabs && shown == BYTE_TAB) begin
      caret = 1'b1;
      shown = BYTE_LETTER_I;
    end
    dollar = opt.show_line_ends && (raw == BYTE_NL);
    if (shown == BYTE_NL) begin
      if (opt.squeeze_blank && blank_run < RUN_SUPPRESS) blank_run++;
    end else begin
      blank_run = '0;
    end
    at_line_start = (raw == BYTE_NL);
    if (blank_run == RUN_SUPPRESS) return;
    if (numbered) begin
      v = line_no;
      do begin
        digit_chars.push_front(BYTE_ZERO + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      for (i = digit_chars.size(); i < NUM_COLS; i++) words.push_back(BYTE_SPACE);
      foreach (digit_chars[j]) words.push_back(digit_chars[j]);
      words.push_back(BYTE_TAB);
    end
    if (caret) words.push_back(BYTE_CARET);
    if (dollar) words.push_back(BYTE_DOLLAR);
    words.push_back(shown);
    foreach (words[j]) expected_words.push_back(shown_word_t'{words[j], j == words.size() - 1});
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct(1'b0)) gap++;
    if (gap > 0) begin
      raw_text.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_text.valid <= 1'b1;
    raw_text.in_byte <= b;
    @(posedge clk);
    while (!raw_text.ready) @(posedge clk);
    predict_display(b);
    items_sent++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    raw_text.valid <= 1'b0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      if (error_count < REPORT_CAP)
        $display("%0t: %0d words missing, expected %h last %b, got none", $time,
                 expected_words.size(), expected_words[0].text, expected_words[0].last);
      error_count += expected_words.size();
      expected_words.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_option(input reg_idx_t idx, input logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SHOW_NONPRINTING: opt.show_nonprinting = value[0];
      REG_SHOW_LINE_ENDS:   opt.show_line_ends = value[0];
      REG_SHOW_TABS:        opt.show_tabs = value[0];
      REG_NUMBERING:        opt.numbering = value;
      REG_SQUEEZE_BLANK:    opt.squeeze_blank = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_options(input tsdf_cfg_t c);
    settle();
    write_option(REG_SHOW_NONPRINTING, 2'(c.show_nonprinting));
    write_option(REG_SHOW_LINE_ENDS, 2'(c.show_line_ends));
    write_option(REG_SHOW_TABS, 2'(c.show_tabs));
    write_option(REG_NUMBERING, c.numbering);
    write_option(REG_SQUEEZE_BLANK, 2'(c.squeeze_blank));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(126, 32));
    if (r < 55) return BYTE_TAB;
    if (r < 60) return BYTE_CR;
    if (r < 70) return 8'($urandom_range(31, 0));
    if (r < 73) return BYTE_DEL;
    if (r < 78) return ($urandom_range(1) == 0) ? WRAP_TAB : WRAP_NL;
    return 8'($urandom_range(255, 128));
  endfunction

  // Mostly lines of text ending in a newline, with runs of blank lines; some raw noise.
  task automatic send_line();
    int len;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
    end else if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(4, 1)) send_byte(BYTE_NL);
    end else begin
      len = $urandom_range(6, 1);
      repeat (len) send_byte(pick_text_byte());
      send_byte(($urandom_range(9) == 0) ? WRAP_NL : BYTE_NL);
    end
  endtask

  task automatic test_plain_text();
    apply_options('0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h41);
    send_byte(BYTE_DEL);
  endtask

  task automatic test_nonprinting();
    apply_options(tsdf_cfg_t'{1'b1, 1'b0, 1'b0, 2'b00, 1'b0});
    send_byte(8'h00);
    send_byte(8'h1f);
    send_byte(8'h80);
    send_byte(WRAP_TAB);
    send_byte(WRAP_NL);
    send_byte(8'hff);
    send_byte(BYTE_CR);
    send_byte(BYTE_DEL);
  endtask

  task automatic test_tabs_and_line_ends();
    apply_options(tsdf_cfg_t'{1'b1, 1'b1, 1'b1, 2'b00, 1'b0});
    send_byte(BYTE_TAB);
    send_byte(WRAP_TAB);
    send_byte(BYTE_NL);
  endtask

  task automatic test_numbered_squeeze();
    apply_options(tsdf_cfg_t'{1'b0, 1'b0, 1'b0, NUM_ALL, 1'b1});
    repeat (3) send_byte(BYTE_NL);
    send_byte(8'h63);
    apply_options(tsdf_cfg_t'{1'b0, 1'b0, 1'b0, NUM_BOTH_BITS, 1'b1});
    repeat (3) send_byte(BYTE_NL);
    // The blank run stays saturated after squeezing is switched off.
    apply_options(tsdf_cfg_t'{1'b0, 1'b0, 1'b0, NUM_BOTH_BITS, 1'b0});
    send_byte(BYTE_NL);
    send_byte(8'h64);
  endtask

  task automatic test_random_text();
    tsdf_cfg_t c;
    int first;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        c = '0;
      end else if (phase == 1) begin
        c = '1;
      end else begin
        c.show_nonprinting = 1'($urandom_range(1));
        c.show_line_ends = 1'($urandom_range(1));
        c.show_tabs = 1'($urandom_range(1));
        c.numbering = 2'($urandom_range(3));
        c.squeeze_blank = 1'($urandom_range(1));
      end
      apply_options(c);
      pace = pace_t'(phase % 4);
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) send_line();
    end
  endtask

  // A newline followed by a high byte that wraps to a newline starts a nonblank line
  // without any output once blank lines are squeezed.
  task automatic test_wrapped_newline_count();
    apply_options(tsdf_cfg_t'{1'b1, 1'b0, 1'b0, NUM_NONBLANK, 1'b1});
    pace = PACE_STEADY;
    repeat (3) send_byte(BYTE_NL);
    repeat (WRAP_PAIRS) begin
      send_byte(BYTE_NL);
      send_byte(WRAP_NL);
    end
    apply_options(tsdf_cfg_t'{1'b0, 1'b0, 1'b0, NUM_ALL, 1'b0});
    send_byte(8'h7a);
    send_byte(BYTE_NL);
    send_byte(8'h7a);
  endtask

  initial begin
    rst = 1'b1;
    raw_text.valid = 1'b0;
    raw_text.in_byte = '0;
    display_text.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_plain_text();
    test_nonprinting();
    test_tabs_and_line_ends();
    test_numbered_squeeze();
    test_random_text();
    test_wrapped_newline_count();
    settle();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tsdf_pkg.sv
hdl/tsdf_ifs.sv
hdl/tsdf_regs.sv
hdl/tsdf_front.sv
hdl/tsdf_queue.sv
hdl/tsdf_back.sv
hdl/text_stream_display_filter_unit.sv
dv/text_stream_display_filter_unit_test.sv
